// ----- src/dnf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnf_pkg
// Shared types, widths, and the multiply-accumulate program for the
// delaunay neighbor filter.
// ----------------------------------------------------------------------------
package dnf_pkg;

  // default capacity of the candidate store
  localparam int NEIGHBORS_DEF = 16;

  // arithmetic widths
  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int LIMB_W  = 25;
  localparam int OPND_W  = 26;
  localparam int PROD_W  = 2 * OPND_W;
  localparam int SQ_W    = 2 * LIMB_W;
  localparam int CR_W    = 2 * LIMB_W + 1;
  localparam int ACC_W   = 104;
  localparam int IDX_OUT_W = 4;

  // input item
  typedef struct packed {
    logic                      req_type;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic                      final_point;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [IDX_OUT_W-1:0] candidate_index;
    logic                 is_neighbor;
    logic                 last_result;
  } out_item_t;

  // one stored point
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  // request kinds
  localparam logic REQ_CENTER = 1'b0;
  localparam logic REQ_CAND   = 1'b1;

  // geometry unit handshake
  typedef struct packed {
    logic start;
    logic circ;
  } geom_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } geom_rsp_t;

  // operand source codes
  localparam int NUM_SRC = 22;
  localparam logic [4:0] SRC_X1  = 5'd0;
  localparam logic [4:0] SRC_Y1  = 5'd1;
  localparam logic [4:0] SRC_X2  = 5'd2;
  localparam logic [4:0] SRC_Y2  = 5'd3;
  localparam logic [4:0] SRC_X3  = 5'd4;
  localparam logic [4:0] SRC_Y3  = 5'd5;
  localparam logic [4:0] SRC_OX1 = 5'd6;
  localparam logic [4:0] SRC_OY1 = 5'd7;
  localparam logic [4:0] SRC_OX2 = 5'd8;
  localparam logic [4:0] SRC_OY2 = 5'd9;
  localparam logic [4:0] SRC_W1L = 5'd10;
  localparam logic [4:0] SRC_W1H = 5'd11;
  localparam logic [4:0] SRC_W2L = 5'd12;
  localparam logic [4:0] SRC_W2H = 5'd13;
  localparam logic [4:0] SRC_W3L = 5'd14;
  localparam logic [4:0] SRC_W3H = 5'd15;
  localparam logic [4:0] SRC_C1L = 5'd16;
  localparam logic [4:0] SRC_C1H = 5'd17;
  localparam logic [4:0] SRC_C2L = 5'd18;
  localparam logic [4:0] SRC_C2H = 5'd19;
  localparam logic [4:0] SRC_C3L = 5'd20;
  localparam logic [4:0] SRC_C3H = 5'd21;

  // accumulator shift codes
  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_25 = 2'd1;
  localparam logic [1:0] SH_50 = 2'd2;

  // accumulator destination codes
  localparam logic [3:0] DST_NONE   = 4'd0;
  localparam logic [3:0] DST_ORIENT = 4'd1;
  localparam logic [3:0] DST_W1     = 4'd2;
  localparam logic [3:0] DST_W2     = 4'd3;
  localparam logic [3:0] DST_W3     = 4'd4;
  localparam logic [3:0] DST_C1     = 4'd5;
  localparam logic [3:0] DST_C2     = 4'd6;
  localparam logic [3:0] DST_C3     = 4'd7;
  localparam logic [3:0] DST_FINAL  = 4'd8;

  typedef struct packed {
    logic [4:0] asel;
    logic [4:0] bsel;
    logic       neg;
    logic [1:0] sh;
    logic       clr;
    logic [3:0] dst;
  } mac_op_t;

  // program entry points
  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_CIRC = 5'd0;
  localparam logic [PC_W-1:0] PC_DIAM = 5'd26;

  // circumcircle program (orient, squares, cross terms, limbed determinant)
  // followed by the two-step diameter dot product
  function automatic mac_op_t mac_op(input logic [PC_W-1:0] pc);
    mac_op_t op;
    case (pc)
      5'd0:  op = '{SRC_OX1, SRC_OY2, 1'b0, SH_0,  1'b1, DST_NONE};
      5'd1:  op = '{SRC_OY1, SRC_OX2, 1'b1, SH_0,  1'b0, DST_ORIENT};
      5'd2:  op = '{SRC_X1,  SRC_X1,  1'b0, SH_0,  1'b1, DST_NONE};
      5'd3:  op = '{SRC_Y1,  SRC_Y1,  1'b0, SH_0,  1'b0, DST_W1};
      5'd4:  op = '{SRC_X2,  SRC_X2,  1'b0, SH_0,  1'b1, DST_NONE};
      5'd5:  op = '{SRC_Y2,  SRC_Y2,  1'b0, SH_0,  1'b0, DST_W2};
      5'd6:  op = '{SRC_X3,  SRC_X3,  1'b0, SH_0,  1'b1, DST_NONE};
      5'd7:  op = '{SRC_Y3,  SRC_Y3,  1'b0, SH_0,  1'b0, DST_W3};
      5'd8:  op = '{SRC_X2,  SRC_Y3,  1'b0, SH_0,  1'b1, DST_NONE};
      5'd9:  op = '{SRC_X3,  SRC_Y2,  1'b1, SH_0,  1'b0, DST_C1};
      5'd10: op = '{SRC_X3,  SRC_Y1,  1'b0, SH_0,  1'b1, DST_NONE};
      5'd11: op = '{SRC_X1,  SRC_Y3,  1'b1, SH_0,  1'b0, DST_C2};
      5'd12: op = '{SRC_X1,  SRC_Y2,  1'b0, SH_0,  1'b1, DST_NONE};
      5'd13: op = '{SRC_X2,  SRC_Y1,  1'b1, SH_0,  1'b0, DST_C3};
      5'd14: op = '{SRC_W1H, SRC_C1H, 1'b0, SH_50, 1'b1, DST_NONE};
      5'd15: op = '{SRC_W1H, SRC_C1L, 1'b0, SH_25, 1'b0, DST_NONE};
      5'd16: op = '{SRC_W1L, SRC_C1H, 1'b0, SH_25, 1'b0, DST_NONE};
      5'd17: op = '{SRC_W1L, SRC_C1L, 1'b0, SH_0,  1'b0, DST_NONE};
      5'd18: op = '{SRC_W2H, SRC_C2H, 1'b0, SH_50, 1'b0, DST_NONE};
      5'd19: op = '{SRC_W2H, SRC_C2L, 1'b0, SH_25, 1'b0, DST_NONE};
      5'd20: op = '{SRC_W2L, SRC_C2H, 1'b0, SH_25, 1'b0, DST_NONE};
      5'd21: op = '{SRC_W2L, SRC_C2L, 1'b0, SH_0,  1'b0, DST_NONE};
      5'd22: op = '{SRC_W3H, SRC_C3H, 1'b0, SH_50, 1'b0, DST_NONE};
      5'd23: op = '{SRC_W3H, SRC_C3L, 1'b0, SH_25, 1'b0, DST_NONE};
      5'd24: op = '{SRC_W3L, SRC_C3H, 1'b0, SH_25, 1'b0, DST_NONE};
      5'd25: op = '{SRC_W3L, SRC_C3L, 1'b0, SH_0,  1'b0, DST_FINAL};
      5'd26: op = '{SRC_X1,  SRC_X2,  1'b0, SH_0,  1'b1, DST_NONE};
      5'd27: op = '{SRC_Y1,  SRC_Y2,  1'b0, SH_0,  1'b0, DST_FINAL};
      default: op = '{SRC_X1, SRC_X1, 1'b0, SH_0, 1'b1, DST_FINAL};
    endcase
    return op;
  endfunction

endpackage

// ----- src/dnf_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dnf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/dnf_geom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnf_geom
// Exact point-in-circle tests on a shared 26x26 multiply-accumulate unit:
// diameter dot product and the 3x3 incircle determinant.
// ----------------------------------------------------------------------------
module dnf_geom (
  input  logic               clk,
  input  logic               rst_n,
  input  dnf_pkg::geom_req_t req,
  input  dnf_pkg::point_t    c,
  input  dnf_pkg::point_t    v,
  input  dnf_pkg::point_t    b,
  input  dnf_pkg::point_t    p,
  output dnf_pkg::geom_rsp_t rsp
);
  import dnf_pkg::*;

  localparam logic [1:0] G_IDLE = 2'd0;
  localparam logic [1:0] G_MUL  = 2'd1;
  localparam logic [1:0] G_ACC  = 2'd2;

  logic [1:0]      state_r;
  logic [PC_W-1:0] pc_r;
  logic            circ_r;
  logic            done_r;
  logic            hit_r;

  logic signed [DIFF_W-1:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r;
  logic signed [DIFF_W-1:0] ox1_r, oy1_r, ox2_r, oy2_r;
  logic [SQ_W-1:0]          w1_r, w2_r, w3_r;
  logic signed [CR_W-1:0]   c1_r, c2_r, c3_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     oneg_r;
  logic                     ozero_r;

  mac_op_t                  op;
  logic signed [OPND_W-1:0] src [NUM_SRC];
  logic signed [OPND_W-1:0] opa, opb;
  logic signed [ACC_W-1:0]  ext, shifted, acc_nxt;
  logic                     res;

  // sign-extended coordinate difference
  function automatic logic signed [DIFF_W-1:0] sub_c(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] z
  );
    return $signed({a[COORD_W-1], a}) - $signed({z[COORD_W-1], z});
  endfunction

  assign op = mac_op(pc_r);

  // operand sources: differences, then low and high limbs of squares and crosses
  assign src[SRC_X1]  = {x1_r[DIFF_W-1], x1_r};
  assign src[SRC_Y1]  = {y1_r[DIFF_W-1], y1_r};
  assign src[SRC_X2]  = {x2_r[DIFF_W-1], x2_r};
  assign src[SRC_Y2]  = {y2_r[DIFF_W-1], y2_r};
  assign src[SRC_X3]  = {x3_r[DIFF_W-1], x3_r};
  assign src[SRC_Y3]  = {y3_r[DIFF_W-1], y3_r};
  assign src[SRC_OX1] = {ox1_r[DIFF_W-1], ox1_r};
  assign src[SRC_OY1] = {oy1_r[DIFF_W-1], oy1_r};
  assign src[SRC_OX2] = {ox2_r[DIFF_W-1], ox2_r};
  assign src[SRC_OY2] = {oy2_r[DIFF_W-1], oy2_r};
  assign src[SRC_W1L] = {1'b0, w1_r[LIMB_W-1:0]};
  assign src[SRC_W1H] = {1'b0, w1_r[SQ_W-1:LIMB_W]};
  assign src[SRC_W2L] = {1'b0, w2_r[LIMB_W-1:0]};
  assign src[SRC_W2H] = {1'b0, w2_r[SQ_W-1:LIMB_W]};
  assign src[SRC_W3L] = {1'b0, w3_r[LIMB_W-1:0]};
  assign src[SRC_W3H] = {1'b0, w3_r[SQ_W-1:LIMB_W]};
  assign src[SRC_C1L] = {1'b0, c1_r[LIMB_W-1:0]};
  assign src[SRC_C1H] = c1_r[CR_W-1:LIMB_W];
  assign src[SRC_C2L] = {1'b0, c2_r[LIMB_W-1:0]};
  assign src[SRC_C2H] = c2_r[CR_W-1:LIMB_W];
  assign src[SRC_C3L] = {1'b0, c3_r[LIMB_W-1:0]};
  assign src[SRC_C3H] = c3_r[CR_W-1:LIMB_W];

  // operand select
  always_comb begin
    opa = '0;
    opb = '0;
    if (op.asel < 5'(NUM_SRC)) begin
      opa = src[op.asel];
    end
    if (op.bsel < 5'(NUM_SRC)) begin
      opb = src[op.bsel];
    end
  end

  // accumulate with limb shift
  always_comb begin
    ext = ACC_W'(prod_r);
    case (op.sh)
      SH_0:    shifted = ext;
      SH_25:   shifted = ext <<< LIMB_W;
      SH_50:   shifted = ext <<< (2 * LIMB_W);
      default: shifted = ext;
    endcase
    acc_nxt = (op.clr ? '0 : acc_r) + (op.neg ? -shifted : shifted);
  end

  // final decision: diameter wants a negative dot, circle the oriented sign
  always_comb begin
    if (!circ_r) begin
      res = acc_nxt[ACC_W-1];
    end else begin
      res = !ozero_r && (acc_nxt != '0) &&
            (oneg_r ? acc_nxt[ACC_W-1] : !acc_nxt[ACC_W-1]);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      done_r  <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        G_IDLE: begin
          if (req.start) begin
            circ_r  <= req.circ;
            state_r <= G_MUL;
            if (req.circ) begin
              pc_r  <= PC_CIRC;
              x1_r  <= sub_c(c.x, p.x);
              y1_r  <= sub_c(c.y, p.y);
              x2_r  <= sub_c(v.x, p.x);
              y2_r  <= sub_c(v.y, p.y);
            end else begin
              pc_r  <= PC_DIAM;
              x1_r  <= sub_c(p.x, c.x);
              y1_r  <= sub_c(p.y, c.y);
              x2_r  <= sub_c(p.x, v.x);
              y2_r  <= sub_c(p.y, v.y);
            end
            x3_r  <= sub_c(b.x, p.x);
            y3_r  <= sub_c(b.y, p.y);
            ox1_r <= sub_c(v.x, c.x);
            oy1_r <= sub_c(v.y, c.y);
            ox2_r <= sub_c(b.x, c.x);
            oy2_r <= sub_c(b.y, c.y);
          end
        end
        G_MUL: begin
          prod_r  <= opa * opb;
          state_r <= G_ACC;
        end
        G_ACC: begin
          acc_r <= acc_nxt;
          case (op.dst)
            DST_ORIENT: begin
              oneg_r  <= acc_nxt[ACC_W-1];
              ozero_r <= (acc_nxt == '0);
            end
            DST_W1:  w1_r <= acc_nxt[SQ_W-1:0];
            DST_W2:  w2_r <= acc_nxt[SQ_W-1:0];
            DST_W3:  w3_r <= acc_nxt[SQ_W-1:0];
            DST_C1:  c1_r <= acc_nxt[CR_W-1:0];
            DST_C2:  c2_r <= acc_nxt[CR_W-1:0];
            DST_C3:  c3_r <= acc_nxt[CR_W-1:0];
            default: ;
          endcase
          if (op.dst == DST_FINAL) begin
            done_r  <= 1'b1;
            hit_r   <= res;
            state_r <= G_IDLE;
          end else begin
            pc_r    <= pc_r + PC_W'(1);
            state_r <= G_MUL;
          end
        end
        default: state_r <= G_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.hit  = hit_r;

endmodule

// ----- src/delaunay_neighbor_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delaunay_neighbor_filter
// Loads a center and candidate points, then reports per candidate whether it
// is a delaunay neighbor of the center, using exact integer circle tests.
// ----------------------------------------------------------------------------
// A center or candidate item is taken while busy is low. The item marked
// final_point then keeps busy high while the stored n candidates are
// evaluated; results come out in load order, one strobe per candidate, and
// last_result marks the final one, with busy low from that cycle on.
// Evaluation runs on the shared 26x26 multiply-accumulate unit, one product
// at a time: per candidate, a diameter test against each other candidate,
// plus for each objector an incircle determinant per third point, stopping
// at the first point found inside. Results are strobed for one cycle and
// cannot be held off.
module delaunay_neighbor_filter #(
  parameter int NEIGHBORS = dnf_pkg::NEIGHBORS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dnf_pkg::in_item_t  in_item,
  output logic               out_valid,
  output dnf_pkg::out_item_t out_item
);
  import dnf_pkg::*;

  localparam int CNT_W = $clog2(NEIGHBORS + 1);
  localparam int IDX_W = $clog2(NEIGHBORS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_VRD   = 4'd1;
  localparam logic [3:0] S_VLD   = 4'd2;
  localparam logic [3:0] S_BCHK  = 4'd3;
  localparam logic [3:0] S_BLD   = 4'd4;
  localparam logic [3:0] S_BWAIT = 4'd5;
  localparam logic [3:0] S_PCHK  = 4'd6;
  localparam logic [3:0] S_PLD   = 4'd7;
  localparam logic [3:0] S_PWAIT = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] v_r, v_nxt;
  logic [CNT_W-1:0] bi_r, bi_nxt;
  logic [CNT_W-1:0] pi_r, pi_nxt;
  point_t           center_r, center_nxt;
  point_t           vpt_r, vpt_nxt;
  point_t           bpt_r, bpt_nxt;
  logic             reject_r, reject_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_raddr;
  point_t           ram_rdata;
  point_t           in_pt;
  logic             can_store;
  logic             last_v;
  geom_req_t        greq;
  geom_rsp_t        grsp;

  assign in_pt.x   = in_item.coord_x;
  assign in_pt.y   = in_item.coord_y;
  assign can_store = (count_r < CNT_W'(NEIGHBORS)) && (in_pt != center_r);
  assign last_v    = ((v_r + CNT_W'(1)) == count_r);

  // candidate store
  dnf_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (NEIGHBORS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (in_pt),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // circle tests
  dnf_geom u_geom (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (greq),
    .c     (center_r),
    .v     (vpt_r),
    .b     (bpt_r),
    .p     (ram_rdata),
    .rsp   (grsp)
  );

  // read address follows the loop that needs the next point
  always_comb begin
    case (state_r)
      S_VRD:   ram_raddr = v_r[IDX_W-1:0];
      S_BCHK:  ram_raddr = bi_r[IDX_W-1:0];
      default: ram_raddr = pi_r[IDX_W-1:0];
    endcase
  end

  // loading and triple walk
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    v_nxt         = v_r;
    bi_nxt        = bi_r;
    pi_nxt        = pi_r;
    center_nxt    = center_r;
    vpt_nxt       = vpt_r;
    bpt_nxt       = bpt_r;
    reject_nxt    = reject_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    greq          = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_item.req_type == REQ_CENTER) begin
            center_nxt = in_pt;
            count_nxt  = '0;
          end else begin
            if (can_store) begin
              ram_we    = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
            if (in_item.final_point && (count_nxt != '0)) begin
              v_nxt     = '0;
              state_nxt = S_VRD;
            end
          end
        end
      end
      S_VRD: state_nxt = S_VLD;
      S_VLD: begin
        vpt_nxt    = ram_rdata;
        bi_nxt     = '0;
        reject_nxt = 1'b0;
        state_nxt  = S_BCHK;
      end
      S_BCHK: begin
        if (bi_r == count_r) begin
          state_nxt = S_EMIT;
        end else if (bi_r == v_r) begin
          bi_nxt = bi_r + CNT_W'(1);
        end else begin
          state_nxt = S_BLD;
        end
      end
      S_BLD: begin
        bpt_nxt    = ram_rdata;
        greq.start = 1'b1;
        greq.circ  = 1'b0;
        state_nxt  = S_BWAIT;
      end
      S_BWAIT: begin
        if (grsp.done) begin
          if (grsp.hit) begin
            pi_nxt    = '0;
            state_nxt = S_PCHK;
          end else begin
            bi_nxt    = bi_r + CNT_W'(1);
            state_nxt = S_BCHK;
          end
        end
      end
      S_PCHK: begin
        if (pi_r == count_r) begin
          bi_nxt    = bi_r + CNT_W'(1);
          state_nxt = S_BCHK;
        end else if ((pi_r == v_r) || (pi_r == bi_r)) begin
          pi_nxt = pi_r + CNT_W'(1);
        end else begin
          state_nxt = S_PLD;
        end
      end
      S_PLD: begin
        greq.start = 1'b1;
        greq.circ  = 1'b1;
        state_nxt  = S_PWAIT;
      end
      S_PWAIT: begin
        if (grsp.done) begin
          if (grsp.hit) begin
            reject_nxt = 1'b1;
            state_nxt  = S_EMIT;
          end else begin
            pi_nxt    = pi_r + CNT_W'(1);
            state_nxt = S_PCHK;
          end
        end
      end
      S_EMIT: begin
        out_valid_nxt                = 1'b1;
        out_item_nxt.candidate_index = IDX_OUT_W'(v_r);
        out_item_nxt.is_neighbor     = !reject_r;
        out_item_nxt.last_result     = last_v;
        if (last_v) begin
          count_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          v_nxt     = v_r + CNT_W'(1);
          state_nxt = S_VRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      center_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      center_r    <= center_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    bi_r       <= bi_nxt;
    pi_r       <= pi_nxt;
    vpt_r      <= vpt_nxt;
    bpt_r      <= bpt_nxt;
    reject_r   <= reject_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- src/dnf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnf_checker
// Port-level checks on the neighbor filter's load and result sequencing.
// ----------------------------------------------------------------------------
module dnf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input dnf_pkg::in_item_t  in_item,
  input logic               out_valid,
  input dnf_pkg::out_item_t out_item
);
  import dnf_pkg::*;

  // results never come in consecutive cycles
  a_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results on consecutive cycles");

  // a center load never starts an evaluation
  a_center_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.req_type == REQ_CENTER)) |=> !busy)
    else $error("busy after center load");

  // a candidate without final_point is taken and leaves the filter idle
  a_cand_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.req_type == REQ_CAND) && !in_item.final_point)
    |=> !busy)
    else $error("busy after plain candidate load");

  // the last result ends the evaluation
  a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last_result) |-> !busy)
    else $error("still busy at last result");

  // any other result comes while the evaluation continues
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last_result) |-> busy)
    else $error("idle before last result");

endmodule

bind delaunay_neighbor_filter dnf_checker u_dnf_checker (.*);
